/* hdl/dmpc_pkg.sv */
// ----------------------------------------------------------------------------
// dmpc_pkg
// Shared constants, register codes, sequencer command codes and the
// saturation and rounding helpers of the dual motor position controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dmpc_pkg;

    // encoder and fixed-point formats
    localparam int COUNT_WIDTH = 16;
    localparam int FRAC_BITS   = 8;
    localparam int FILT_SHIFT  = 8;
    localparam int POS_SHIFT   = 16;

    // shared multiplier and accumulator widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int DRV_W   = ACC_W - FRAC_BITS;

    // stream and configuration port widths
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_KP        = 3'd0;
    localparam cfg_idx_t REG_KI        = 3'd1;
    localparam cfg_idx_t REG_KD        = 3'd2;
    localparam cfg_idx_t REG_RATE      = 3'd3;
    localparam cfg_idx_t REG_FILT      = 3'd4;
    localparam cfg_idx_t REG_THRESHOLD = 3'd5;
    localparam cfg_idx_t REG_CPM       = 3'd6;
    localparam cfg_idx_t REG_MM2C      = 3'd7;

    // configuration reset values
    localparam logic [15:0] KP_RESET        = 16'd384;
    localparam logic [15:0] KI_RESET        = 16'd26;
    localparam logic [15:0] KD_RESET        = 16'd77;
    localparam logic [9:0]  RATE_RESET      = 10'd50;
    localparam logic [8:0]  FILT_RESET      = 9'd43;
    localparam logic [9:0]  THRESHOLD_RESET = 10'd10;
    localparam logic [15:0] CPM_RESET       = 16'd2074;
    localparam logic [15:0] MM2C_RESET      = 16'd4045;
    localparam logic [7:0]  MAX_DRIVE_RESET = 8'd200;
    localparam logic [8:0]  FILT_UNITY      = 9'd256;

    typedef struct packed {
        logic [15:0] kp_gain;
        logic [15:0] ki_gain;
        logic [15:0] kd_gain;
        logic [9:0]  rate_scale;
        logic [8:0]  filter_weight;
        logic [9:0]  arrive_threshold;
        logic [15:0] counts_per_mm;
        logic [15:0] mm_per_two_counts;
    } cfg_t;

    // multiplier operand pair select
    typedef logic [3:0] mul_t;
    localparam mul_t MUL_NONE     = 4'd0;
    localparam mul_t MUL_RATE     = 4'd1;
    localparam mul_t MUL_FILT_OLD = 4'd2;
    localparam mul_t MUL_FILT_NEW = 4'd3;
    localparam mul_t MUL_P        = 4'd4;
    localparam mul_t MUL_I        = 4'd5;
    localparam mul_t MUL_D        = 4'd6;
    localparam mul_t MUL_POS_X    = 4'd7;
    localparam mul_t MUL_POS_Y    = 4'd8;
    localparam mul_t MUL_GOAL_ONE = 4'd9;
    localparam mul_t MUL_GOAL_TWO = 4'd10;

    // accumulator action
    typedef logic [1:0] acc_t;
    localparam acc_t ACC_HOLD = 2'd0;
    localparam acc_t ACC_LOAD = 2'd1;
    localparam acc_t ACC_ADD  = 2'd2;

    // datapath writeback operation
    typedef logic [3:0] op_t;
    localparam op_t OP_NONE     = 4'd0;
    localparam op_t OP_SPEED    = 4'd1;
    localparam op_t OP_GOAL_ONE = 4'd2;
    localparam op_t OP_GOAL_TWO = 4'd3;
    localparam op_t OP_POS_X    = 4'd4;
    localparam op_t OP_POS_Y    = 4'd5;
    localparam op_t OP_ERR      = 4'd6;
    localparam op_t OP_INT      = 4'd7;
    localparam op_t OP_RATE     = 4'd8;
    localparam op_t OP_FILT     = 4'd9;
    localparam op_t OP_DRIVE    = 4'd10;
    localparam op_t OP_FINISH   = 4'd11;
    localparam op_t OP_OFF      = 4'd12;

    typedef struct packed {
        logic capture;
        logic ch;
        mul_t mul;
        acc_t acc;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic is_target;
        logic move_enable;
        logic target_changed;
        logic out_free;
    } stat_t;

    // arithmetic shift right that rounds toward zero
    function automatic logic signed [ACC_W-1:0] shr_trunc(
        input logic signed [ACC_W-1:0] v,
        input int                      sh
    );
        logic signed [ACC_W-1:0] bias;
        bias = (ACC_W'(1) <<< sh) - ACC_W'(1);
        if (v[ACC_W-1]) begin
            return (v + bias) >>> sh;
        end
        return v >>> sh;
    endfunction

    // saturate to 32-bit signed
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-32:0] upper;
        upper = v[ACC_W-1:31];
        if (upper == '0 || upper == '1) begin
            return v[31:0];
        end
        if (v[ACC_W-1]) begin
            return 32'sh8000_0000;
        end
        return 32'sh7FFF_FFFF;
    endfunction

    // saturate to the 13-bit signed position range
    function automatic logic signed [12:0] sat_pos(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-13:0] upper;
        upper = v[ACC_W-1:12];
        if (upper == '0 || upper == '1) begin
            return v[12:0];
        end
        if (v[ACC_W-1]) begin
            return 13'sh1000;
        end
        return 13'sh0FFF;
    endfunction

endpackage

`default_nettype wire

/* hdl/dmpc_regs.sv */
// ----------------------------------------------------------------------------
// dmpc_regs
// Configuration register bank: gains, filter, threshold and scale factors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmpc_regs (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [dmpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dmpc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output dmpc_pkg::cfg_t                        cfg
);
    import dmpc_pkg::*;

    cfg_t cfg_reg;

    // register writes, one index per transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp_gain           <= KP_RESET;
            cfg_reg.ki_gain           <= KI_RESET;
            cfg_reg.kd_gain           <= KD_RESET;
            cfg_reg.rate_scale        <= RATE_RESET;
            cfg_reg.filter_weight     <= FILT_RESET;
            cfg_reg.arrive_threshold  <= THRESHOLD_RESET;
            cfg_reg.counts_per_mm     <= CPM_RESET;
            cfg_reg.mm_per_two_counts <= MM2C_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_KP:        cfg_reg.kp_gain           <= cfg_data;
                REG_KI:        cfg_reg.ki_gain           <= cfg_data;
                REG_KD:        cfg_reg.kd_gain           <= cfg_data;
                REG_RATE:      cfg_reg.rate_scale        <= cfg_data[9:0];
                REG_FILT:      cfg_reg.filter_weight     <= cfg_data[8:0];
                REG_THRESHOLD: cfg_reg.arrive_threshold  <= cfg_data[9:0];
                REG_CPM:       cfg_reg.counts_per_mm     <= cfg_data;
                REG_MM2C:      cfg_reg.mm_per_two_counts <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* hdl/dmpc_ctrl.sv */
// ----------------------------------------------------------------------------
// dmpc_ctrl
// Sequencer: steps the shared multiplier and writeback operations through
// the set-target and control-tick schedules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmpc_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire dmpc_pkg::stat_t stat,
    output dmpc_pkg::cmd_t       cmd
);
    import dmpc_pkg::*;

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_DECODE  = 5'd1;
    localparam logic [4:0] ST_GOAL_M1 = 5'd2;
    localparam logic [4:0] ST_GOAL_M2 = 5'd3;
    localparam logic [4:0] ST_GOAL_W2 = 5'd4;
    localparam logic [4:0] ST_POS_MX  = 5'd5;
    localparam logic [4:0] ST_POS_MY  = 5'd6;
    localparam logic [4:0] ST_POS_WY  = 5'd7;
    localparam logic [4:0] ST_ERR     = 5'd8;
    localparam logic [4:0] ST_INT     = 5'd9;
    localparam logic [4:0] ST_RATE_M  = 5'd10;
    localparam logic [4:0] ST_RATE_W  = 5'd11;
    localparam logic [4:0] ST_FILT_A  = 5'd12;
    localparam logic [4:0] ST_FILT_B  = 5'd13;
    localparam logic [4:0] ST_FILT_W  = 5'd14;
    localparam logic [4:0] ST_P_M     = 5'd15;
    localparam logic [4:0] ST_I_M     = 5'd16;
    localparam logic [4:0] ST_D_M     = 5'd17;
    localparam logic [4:0] ST_D_A     = 5'd18;
    localparam logic [4:0] ST_DRV_W   = 5'd19;
    localparam logic [4:0] ST_FIN     = 5'd20;
    localparam logic [4:0] ST_OFF     = 5'd21;

    logic [4:0] state_reg, state_next;
    logic       ch_reg, ch_next;

    // next state and command decode
    always_comb begin
        state_next  = state_reg;
        ch_next     = ch_reg;
        cmd.capture = 1'b0;
        cmd.ch      = ch_reg;
        cmd.mul     = MUL_NONE;
        cmd.acc     = ACC_HOLD;
        cmd.op      = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (stat.is_target) begin
                    cmd.op     = OP_SPEED;
                    state_next = stat.target_changed ? ST_GOAL_M1 : ST_IDLE;
                end else if (stat.move_enable) begin
                    state_next = ST_POS_MX;
                end else begin
                    state_next = ST_OFF;
                end
            end
            ST_GOAL_M1: begin
                cmd.mul    = MUL_GOAL_ONE;
                state_next = ST_GOAL_M2;
            end
            ST_GOAL_M2: begin
                cmd.op     = OP_GOAL_ONE;
                cmd.mul    = MUL_GOAL_TWO;
                state_next = ST_GOAL_W2;
            end
            ST_GOAL_W2: begin
                cmd.op     = OP_GOAL_TWO;
                state_next = ST_IDLE;
            end
            ST_POS_MX: begin
                cmd.mul    = MUL_POS_X;
                state_next = ST_POS_MY;
            end
            ST_POS_MY: begin
                cmd.op     = OP_POS_X;
                cmd.mul    = MUL_POS_Y;
                state_next = ST_POS_WY;
            end
            ST_POS_WY: begin
                cmd.op     = OP_POS_Y;
                ch_next    = 1'b0;
                state_next = ST_ERR;
            end
            ST_ERR: begin
                cmd.op     = OP_ERR;
                state_next = ST_INT;
            end
            ST_INT: begin
                cmd.op     = OP_INT;
                state_next = ST_RATE_M;
            end
            ST_RATE_M: begin
                cmd.mul    = MUL_RATE;
                state_next = ST_RATE_W;
            end
            ST_RATE_W: begin
                cmd.op     = OP_RATE;
                cmd.mul    = MUL_FILT_OLD;
                state_next = ST_FILT_A;
            end
            ST_FILT_A: begin
                cmd.acc    = ACC_LOAD;
                cmd.mul    = MUL_FILT_NEW;
                state_next = ST_FILT_B;
            end
            ST_FILT_B: begin
                cmd.acc    = ACC_ADD;
                state_next = ST_FILT_W;
            end
            ST_FILT_W: begin
                cmd.op     = OP_FILT;
                state_next = ST_P_M;
            end
            ST_P_M: begin
                cmd.mul    = MUL_P;
                state_next = ST_I_M;
            end
            ST_I_M: begin
                cmd.acc    = ACC_LOAD;
                cmd.mul    = MUL_I;
                state_next = ST_D_M;
            end
            ST_D_M: begin
                cmd.acc    = ACC_ADD;
                cmd.mul    = MUL_D;
                state_next = ST_D_A;
            end
            ST_D_A: begin
                cmd.acc    = ACC_ADD;
                state_next = ST_DRV_W;
            end
            ST_DRV_W: begin
                cmd.op = OP_DRIVE;
                if (ch_reg) begin
                    state_next = ST_FIN;
                end else begin
                    ch_next    = 1'b1;
                    state_next = ST_ERR;
                end
            end
            // wait for the output slot, then publish the result
            ST_FIN: begin
                if (stat.out_free) begin
                    cmd.op     = OP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            ST_OFF: begin
                if (stat.out_free) begin
                    cmd.op     = OP_OFF;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ch_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

/* hdl/dmpc_datapath.sv */
// ----------------------------------------------------------------------------
// dmpc_datapath
// Item register, shared 33x17 multiplier with accumulator, controller state
// of both channels and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmpc_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire dmpc_pkg::cmd_t                  cmd,
    output dmpc_pkg::stat_t                      stat,
    input  wire dmpc_pkg::cfg_t                  cfg,
    input  wire logic [dmpc_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [dmpc_pkg::M_TDATA_W-1:0]       m_tdata
);
    import dmpc_pkg::*;

    // captured item
    logic               func_reg;
    logic [15:0]        cnt_one_reg, cnt_two_reg;
    logic               enable_reg;
    logic signed [11:0] tx_reg, ty_reg;
    logic [7:0]         speed_reg;

    // persistent controller state
    logic signed [31:0] goal_one_reg, goal_two_reg;
    logic signed [11:0] goal_x_reg, goal_y_reg;
    logic signed [31:0] last_e_one_reg, last_e_two_reg;
    logic signed [31:0] integ_one_reg, integ_two_reg;
    logic signed [31:0] filt_one_reg, filt_two_reg;
    logic [7:0]         max_drive_reg;
    logic               held_rev_one_reg, held_rev_two_reg, held_arr_reg;
    logic signed [12:0] held_px_reg, held_py_reg;

    // working registers
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [31:0]        e_reg, rate_reg;
    logic signed [MUL_A_W-1:0] diff_reg;
    logic signed [DRV_W-1:0]   drive_one_reg, drive_two_reg;

    // output stage
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // capture the accepted transaction
    // s_tdata: count_one, count_two, move_enable, target_x_mm, target_y_mm, speed_limit
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg    <= s_tuser;
            cnt_one_reg <= s_tdata[15:0];
            cnt_two_reg <= s_tdata[31:16];
            enable_reg  <= s_tdata[32];
            tx_reg      <= s_tdata[44:33];
            ty_reg      <= s_tdata[56:45];
            speed_reg   <= s_tdata[64:57];
        end
    end

    // operand extension
    logic signed [MUL_A_W-1:0] c_one_ext, c_two_ext, tx_ext, ty_ext, cnt_sel;
    assign c_one_ext = MUL_A_W'(signed'(cnt_one_reg[COUNT_WIDTH-1:0]));
    assign c_two_ext = MUL_A_W'(signed'(cnt_two_reg[COUNT_WIDTH-1:0]));
    assign tx_ext    = MUL_A_W'(tx_reg);
    assign ty_ext    = MUL_A_W'(ty_reg);

    // channel select
    logic signed [31:0] goal_sel, last_e_sel, integ_sel, filt_sel;
    assign goal_sel   = cmd.ch ? goal_two_reg   : goal_one_reg;
    assign last_e_sel = cmd.ch ? last_e_two_reg : last_e_one_reg;
    assign integ_sel  = cmd.ch ? integ_two_reg  : integ_one_reg;
    assign filt_sel   = cmd.ch ? filt_two_reg   : filt_one_reg;
    assign cnt_sel    = cmd.ch ? c_two_ext      : c_one_ext;

    // filter weight limited to unity
    logic [8:0] fw_lim, fw_inv;
    assign fw_lim = (cfg.filter_weight > FILT_UNITY) ? FILT_UNITY : cfg.filter_weight;
    assign fw_inv = FILT_UNITY - fw_lim;

    // multiplier operand select
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul)
            MUL_RATE: begin
                mul_a = diff_reg;
                mul_b = {7'd0, cfg.rate_scale};
            end
            MUL_FILT_OLD: begin
                mul_a = MUL_A_W'(filt_sel);
                mul_b = {8'd0, fw_inv};
            end
            MUL_FILT_NEW: begin
                mul_a = MUL_A_W'(rate_reg);
                mul_b = {8'd0, fw_lim};
            end
            MUL_P: begin
                mul_a = MUL_A_W'(e_reg);
                mul_b = {1'b0, cfg.kp_gain};
            end
            MUL_I: begin
                mul_a = MUL_A_W'(integ_sel);
                mul_b = {1'b0, cfg.ki_gain};
            end
            MUL_D: begin
                mul_a = MUL_A_W'(filt_sel);
                mul_b = {1'b0, cfg.kd_gain};
            end
            MUL_POS_X: begin
                mul_a = c_one_ext + c_two_ext;
                mul_b = {1'b0, cfg.mm_per_two_counts};
            end
            MUL_POS_Y: begin
                mul_a = c_two_ext - c_one_ext;
                mul_b = {1'b0, cfg.mm_per_two_counts};
            end
            MUL_GOAL_ONE: begin
                mul_a = tx_ext - ty_ext;
                mul_b = {1'b0, cfg.counts_per_mm};
            end
            MUL_GOAL_TWO: begin
                mul_a = tx_ext + ty_ext;
                mul_b = {1'b0, cfg.counts_per_mm};
            end
            default: ;
        endcase
    end

    // product register and accumulator
    logic signed [ACC_W-1:0] prod_ext;
    assign prod_ext = ACC_W'(prod_reg);

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        case (cmd.acc)
            ACC_LOAD: acc_reg <= prod_ext;
            ACC_ADD:  acc_reg <= acc_reg + prod_ext;
            default:  ;
        endcase
    end

    // writeback values
    logic signed [31:0]        e_next, integ_next, rate_next, filt_next, goal_next;
    logic signed [MUL_A_W-1:0] diff_next;
    logic signed [DRV_W-1:0]   drive_next;
    logic signed [12:0]        pos_next;
    assign e_next     = sat32(ACC_W'(goal_sel) - ACC_W'(cnt_sel));
    assign integ_next = sat32(ACC_W'(integ_sel) + ACC_W'(e_reg));
    assign diff_next  = MUL_A_W'(e_reg) - MUL_A_W'(last_e_sel);
    assign rate_next  = sat32(prod_ext);
    assign filt_next  = sat32(shr_trunc(acc_reg, FILT_SHIFT));
    assign drive_next = DRV_W'(shr_trunc(acc_reg, FRAC_BITS));
    assign goal_next  = sat32(shr_trunc(prod_ext, FRAC_BITS));
    assign pos_next   = sat_pos(shr_trunc(prod_ext, POS_SHIFT));

    // arrival test on both errors
    logic [32:0] e_one_abs, e_two_abs;
    logic        arrived_now;
    assign e_one_abs = last_e_one_reg[31] ? (33'd0 - 33'(last_e_one_reg)) : 33'(last_e_one_reg);
    assign e_two_abs = last_e_two_reg[31] ? (33'd0 - 33'(last_e_two_reg)) : 33'(last_e_two_reg);
    assign arrived_now = (e_one_abs < 33'(cfg.arrive_threshold))
                      && (e_two_abs < 33'(cfg.arrive_threshold));

    // magnitude, direction and clamp to the speed limit
    logic [DRV_W-1:0] d_one_abs, d_two_abs;
    logic [7:0]       pwm_one, pwm_two;
    logic             rev_one, rev_two;
    assign d_one_abs = drive_one_reg[DRV_W-1] ? (DRV_W'(0) - drive_one_reg) : drive_one_reg;
    assign d_two_abs = drive_two_reg[DRV_W-1] ? (DRV_W'(0) - drive_two_reg) : drive_two_reg;
    assign pwm_one = arrived_now ? 8'd0 :
                     (d_one_abs > DRV_W'(max_drive_reg)) ? max_drive_reg : d_one_abs[7:0];
    assign pwm_two = arrived_now ? 8'd0 :
                     (d_two_abs > DRV_W'(max_drive_reg)) ? max_drive_reg : d_two_abs[7:0];
    assign rev_one = !arrived_now && drive_one_reg[DRV_W-1];
    assign rev_two = !arrived_now && drive_two_reg[DRV_W-1];

    // working registers of the channel sequence
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_ERR:  e_reg    <= e_next;
            OP_INT:  diff_reg <= diff_next;
            OP_RATE: rate_reg <= rate_next;
            OP_DRIVE: begin
                if (cmd.ch) begin
                    drive_two_reg <= drive_next;
                end else begin
                    drive_one_reg <= drive_next;
                end
            end
            default: ;
        endcase
    end

    // persistent state updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goal_one_reg     <= '0;
            goal_two_reg     <= '0;
            goal_x_reg       <= '0;
            goal_y_reg       <= '0;
            last_e_one_reg   <= '0;
            last_e_two_reg   <= '0;
            integ_one_reg    <= '0;
            integ_two_reg    <= '0;
            filt_one_reg     <= '0;
            filt_two_reg     <= '0;
            max_drive_reg    <= MAX_DRIVE_RESET;
            held_rev_one_reg <= 1'b0;
            held_rev_two_reg <= 1'b0;
            held_arr_reg     <= 1'b0;
            held_px_reg      <= '0;
            held_py_reg      <= '0;
        end else begin
            case (cmd.op)
                OP_SPEED: max_drive_reg <= speed_reg;
                OP_GOAL_ONE: goal_one_reg <= goal_next;
                // new target: clear errors and integrals
                OP_GOAL_TWO: begin
                    goal_two_reg   <= goal_next;
                    goal_x_reg     <= tx_reg;
                    goal_y_reg     <= ty_reg;
                    last_e_one_reg <= '0;
                    last_e_two_reg <= '0;
                    integ_one_reg  <= '0;
                    integ_two_reg  <= '0;
                end
                OP_POS_X: held_px_reg <= pos_next;
                OP_POS_Y: held_py_reg <= pos_next;
                OP_INT: begin
                    if (cmd.ch) begin
                        integ_two_reg  <= integ_next;
                        last_e_two_reg <= e_reg;
                    end else begin
                        integ_one_reg  <= integ_next;
                        last_e_one_reg <= e_reg;
                    end
                end
                OP_FILT: begin
                    if (cmd.ch) begin
                        filt_two_reg <= filt_next;
                    end else begin
                        filt_one_reg <= filt_next;
                    end
                end
                OP_FINISH: begin
                    held_rev_one_reg <= rev_one;
                    held_rev_two_reg <= rev_two;
                    held_arr_reg     <= arrived_now;
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.op == OP_FINISH || cmd.op == OP_OFF) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_FINISH) begin
            m_tdata_reg <= {3'd0, arrived_now, held_py_reg, held_px_reg,
                            rev_two, pwm_two, rev_one, pwm_one};
        end else if (cmd.op == OP_OFF) begin
            m_tdata_reg <= {3'd0, held_arr_reg, held_py_reg, held_px_reg,
                            held_rev_two_reg, 8'd0, held_rev_one_reg, 8'd0};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // status to the sequencer
    assign stat.is_target      = func_reg;
    assign stat.move_enable    = enable_reg;
    assign stat.target_changed = (tx_reg != goal_x_reg) || (ty_reg != goal_y_reg);
    assign stat.out_free       = !m_tvalid_reg || m_tready;

endmodule

`default_nettype wire

/* hdl/dual_motor_pid_position_controller_top.sv */
// ----------------------------------------------------------------------------
// dual_motor_pid_position_controller_top
// Two-channel position PID with filtered derivative for an x/y motor stage.
// ----------------------------------------------------------------------------
// A set-target transaction (tuser high) maps the x/y target to two encoder
// goals and stores the speed limit; it gives no result, and the goals are
// recomputed only when the target changes. A control tick (tuser low) gives
// one result: zero PWM and held status when move_enable is low; when it is
// high, the single shared 33x17 multiplier and its accumulator run the
// position, error rate, derivative filter and PID sum of both channels in
// turn. One item is worked at a time; a finished result waits in the
// output register while the next item is taken, and a tick stalls at its
// end only while an earlier result is still untaken. The user must write
// Configuration through cfg_we/cfg_index/cfg_data while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dual_motor_pid_position_controller_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // s_tdata: count_one[15:0], count_two[31:16], move_enable[32],
    //          target_x_mm[44:33], target_y_mm[56:45], speed_limit[64:57]
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [dmpc_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: func (0 control tick, 1 set target)
    input  wire logic                             s_tuser,
    // m_tdata: pwm_one[7:0], reverse_one[8], pwm_two[16:9], reverse_two[17],
    //          position_x_mm[30:18], position_y_mm[43:31], arrived[44]
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [dmpc_pkg::M_TDATA_W-1:0]        m_tdata,
    input  wire logic                             cfg_we,
    input  wire logic [dmpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dmpc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dmpc_pkg::*;

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    // configuration registers
    dmpc_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer
    dmpc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // arithmetic and state
    dmpc_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .cfg      (cfg),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
